// File: rtl/rlcd_pkg.sv
// ----------------------------------------------------------------------------
// rlcd_pkg
// Shared widths, register indexes and the fixed chord band table of the
// resistor ladder chord decoder.
// ----------------------------------------------------------------------------
package rlcd_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int BAND_COUNT  = 11;
    localparam int MASK_BITS   = 4;
    localparam int HYST_BITS   = 8;
    localparam int COUNT_BITS  = 4;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 12;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [MASK_BITS-1:0]   mask_t;
    typedef logic [COUNT_BITS-1:0]  count_t;

    // register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_IDLE_MAX     = 3'd0,
        REG_PLAY_FLOOR   = 3'd1,
        REG_HYSTERESIS   = 3'd2,
        REG_SLEW_MAX     = 3'd3,
        REG_SETTLE_READS = 3'd4
    } reg_idx_t;

    // register reset values
    localparam sample_t IDLE_MAX_RST     = 12'd64;
    localparam sample_t PLAY_FLOOR_RST   = 12'd1600;
    localparam logic [HYST_BITS-1:0] HYSTERESIS_RST = 8'd16;
    localparam sample_t SLEW_MAX_RST     = 12'd100;
    localparam count_t  SETTLE_READS_RST = 4'd3;

    localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        sample_t lo;
        sample_t hi;
        mask_t   mask;
    } band_t;

    // chord bands in ascending order, T3+T4 chords have no band
    localparam band_t BANDS [BAND_COUNT] = '{
        '{lo: 12'd129,  hi: 12'd253,  mask: 4'h1},
        '{lo: 12'd363,  hi: 12'd440,  mask: 4'h2},
        '{lo: 12'd541,  hi: 12'd610,  mask: 4'h3},
        '{lo: 12'd700,  hi: 12'd764,  mask: 4'h4},
        '{lo: 12'd849,  hi: 12'd907,  mask: 4'h5},
        '{lo: 12'd984,  hi: 12'd1038, mask: 4'h6},
        '{lo: 12'd1110, hi: 12'd1154, mask: 4'h7},
        '{lo: 12'd1202, hi: 12'd1243, mask: 4'h8},
        '{lo: 12'd1306, hi: 12'd1350, mask: 4'h9},
        '{lo: 12'd1408, hi: 12'd1448, mask: 4'hA},
        '{lo: 12'd1503, hi: 12'd1541, mask: 4'hB}
    };

endpackage

// File: rtl/resistor_ladder_chord_decoder_core.sv
// ----------------------------------------------------------------------------
// resistor_ladder_chord_decoder_core
// Decodes one ladder converter sample per request into the debounced mask of
// the four buttons held, with slew guard, band hysteresis and settle count.
// ----------------------------------------------------------------------------
//
//  channel     dir   handshake                          payload
//  ---------   ---   --------------------------------   ----------------------
//  sample      in    sample_valid / sample_ready        sample [11:0]
//  chord_mask  out   chord_mask_valid / chord_mask_ready chord_mask [3:0]
//  cfg         in    cfg_wr_en (no wait)                cfg_index, cfg_wr_data
//
//  one request per cycle sustained while chord_mask_ready is high; an accepted
//  request passes the input register, then the decode step into the result
//  register, before the result is valid
//  the decode step reads and updates the debounce state in the same cycle,
//  so consecutive requests see each other's updates without a bubble
//  a stalled result holds in the result register while one more request
//  waits in the input register; sample_ready drops only when both are full
//  reset clears the debounce state and loads the register reset values
//
module resistor_ladder_chord_decoder_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  logic [rlcd_pkg::SAMPLE_BITS-1:0]    sample,
    output logic                                chord_mask_valid,
    input  logic                                chord_mask_ready,
    output logic [rlcd_pkg::MASK_BITS-1:0]      chord_mask,
    input  logic                                cfg_wr_en,
    input  logic [rlcd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [rlcd_pkg::CFG_DATA_BITS-1:0]  cfg_wr_data
);

    // configuration registers
    rlcd_pkg::sample_t                    idle_max_reg;
    rlcd_pkg::sample_t                    play_floor_reg;
    logic [rlcd_pkg::HYST_BITS-1:0]       hysteresis_reg;
    rlcd_pkg::sample_t                    slew_max_reg;
    rlcd_pkg::count_t                     settle_reads_reg;

    // input register
    logic                                 in_valid_reg;
    rlcd_pkg::sample_t                    in_sample_reg;

    // debounce state
    rlcd_pkg::mask_t                      settled_mask_reg;
    rlcd_pkg::mask_t                      settled_mask_next;
    rlcd_pkg::mask_t                      candidate_mask_reg;
    rlcd_pkg::mask_t                      candidate_mask_next;
    rlcd_pkg::count_t                     candidate_count_reg;
    rlcd_pkg::count_t                     candidate_count_next;
    logic                                 prior_valid_reg;
    rlcd_pkg::sample_t                    prior_sample_reg;

    // result register
    logic                                 out_valid_reg;
    rlcd_pkg::mask_t                      out_mask_reg;

    logic                                 advance;
    logic                                 fire;
    logic                                 is_idle;
    logic                                 slew_hold;
    rlcd_pkg::sample_t                    diff;
    logic                                 hit;
    rlcd_pkg::mask_t                      seen;
    rlcd_pkg::count_t                     count_inc;

    // ------------------------------------------------------------------------
    // handshake: the decode step moves when the result register is free
    // ------------------------------------------------------------------------
    assign advance      = !out_valid_reg || chord_mask_ready;
    assign fire         = in_valid_reg && advance;
    assign sample_ready = !in_valid_reg || advance;

    assign chord_mask_valid = out_valid_reg;
    assign chord_mask       = out_mask_reg;

    // ------------------------------------------------------------------------
    // slew guard, idle samples are never held by it
    // ------------------------------------------------------------------------
    assign is_idle   = (in_sample_reg <= idle_max_reg);
    assign diff      = (in_sample_reg >= prior_sample_reg) ?
                       (in_sample_reg - prior_sample_reg) :
                       (prior_sample_reg - in_sample_reg);
    assign slew_hold = prior_valid_reg && !is_idle && (diff > slew_max_reg);

    // ------------------------------------------------------------------------
    // band classification: all bands compared in parallel, first hit wins
    // widened edges are compared with the hysteresis moved to the other side,
    // so a lower edge below zero needs no signed math
    // ------------------------------------------------------------------------
    always_comb
    begin
        logic [rlcd_pkg::SAMPLE_BITS:0] s_ext;
        logic [rlcd_pkg::SAMPLE_BITS:0] s_up;
        logic [rlcd_pkg::SAMPLE_BITS:0] hi_up;
        logic [rlcd_pkg::SAMPLE_BITS:0] lo_ext;
        logic                           widen;
        logic                           in_band;

        s_ext  = {1'b0, in_sample_reg};
        s_up   = '0;
        hi_up  = '0;
        lo_ext = '0;
        widen  = 1'b0;
        in_band = 1'b0;
        hit    = 1'b0;
        seen   = '0;
        if (is_idle)
        begin
            hit  = 1'b1;
            seen = '0;
        end
        else if (in_sample_reg < play_floor_reg)
        begin
            for (int i = 0; i < rlcd_pkg::BAND_COUNT; i++)
            begin
                widen  = (settled_mask_reg != '0) &&
                         (rlcd_pkg::BANDS[i].mask == settled_mask_reg);
                lo_ext = {1'b0, rlcd_pkg::BANDS[i].lo};
                if (widen)
                begin
                    s_up  = s_ext + {{(rlcd_pkg::SAMPLE_BITS + 1
                                      - rlcd_pkg::HYST_BITS){1'b0}}, hysteresis_reg};
                    hi_up = {1'b0, rlcd_pkg::BANDS[i].hi}
                          + {{(rlcd_pkg::SAMPLE_BITS + 1
                               - rlcd_pkg::HYST_BITS){1'b0}}, hysteresis_reg};
                end
                else
                begin
                    s_up  = s_ext;
                    hi_up = {1'b0, rlcd_pkg::BANDS[i].hi};
                end
                in_band = (s_up >= lo_ext) && (s_ext <= hi_up);
                if (!hit && in_band)
                begin
                    hit  = 1'b1;
                    seen = rlcd_pkg::BANDS[i].mask;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // debounce update
    // ------------------------------------------------------------------------
    assign count_inc = (seen != candidate_mask_reg) ? rlcd_pkg::count_t'(1) :
                       (candidate_count_reg == rlcd_pkg::COUNT_MAX) ? candidate_count_reg :
                       candidate_count_reg + rlcd_pkg::count_t'(1);

    always_comb
    begin
        settled_mask_next    = settled_mask_reg;
        candidate_mask_next  = candidate_mask_reg;
        candidate_count_next = candidate_count_reg;
        priority if (slew_hold)
        begin
            candidate_mask_next  = settled_mask_reg;
            candidate_count_next = '0;
        end
        else if (!hit || (seen == settled_mask_reg))
        begin
            candidate_mask_next  = settled_mask_reg;
            candidate_count_next = '0;
        end
        else if (seen == '0)
        begin
            settled_mask_next    = '0;
            candidate_mask_next  = '0;
            candidate_count_next = '0;
        end
        else
        begin
            // a settle count of zero acts as one: count_inc is never zero
            candidate_mask_next = seen;
            if (count_inc >= settle_reads_reg)
            begin
                settled_mask_next    = seen;
                candidate_count_next = '0;
            end
            else
            begin
                candidate_count_next = count_inc;
            end
        end
    end

    // ------------------------------------------------------------------------
    // configuration registers, writes beyond the last index are dropped
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_max_reg     <= rlcd_pkg::IDLE_MAX_RST;
            play_floor_reg   <= rlcd_pkg::PLAY_FLOOR_RST;
            hysteresis_reg   <= rlcd_pkg::HYSTERESIS_RST;
            slew_max_reg     <= rlcd_pkg::SLEW_MAX_RST;
            settle_reads_reg <= rlcd_pkg::SETTLE_READS_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                rlcd_pkg::REG_IDLE_MAX:     idle_max_reg     <= cfg_wr_data;
                rlcd_pkg::REG_PLAY_FLOOR:   play_floor_reg   <= cfg_wr_data;
                rlcd_pkg::REG_HYSTERESIS:
                    hysteresis_reg <= cfg_wr_data[rlcd_pkg::HYST_BITS-1:0];
                rlcd_pkg::REG_SLEW_MAX:     slew_max_reg     <= cfg_wr_data;
                rlcd_pkg::REG_SETTLE_READS:
                    settle_reads_reg <= cfg_wr_data[rlcd_pkg::COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // input register, state and result register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            settled_mask_reg    <= '0;
            candidate_mask_reg  <= '0;
            candidate_count_reg <= '0;
            prior_valid_reg     <= 1'b0;
            prior_sample_reg    <= '0;
        end
        else
        begin
            if (sample_ready)
            begin
                in_valid_reg <= sample_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                settled_mask_reg    <= settled_mask_next;
                candidate_mask_reg  <= candidate_mask_next;
                candidate_count_reg <= candidate_count_next;
                prior_valid_reg     <= 1'b1;
                prior_sample_reg    <= in_sample_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_ready && sample_valid)
        begin
            in_sample_reg <= sample;
        end
        if (fire)
        begin
            out_mask_reg <= settled_mask_next;
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // no band names a chord with both T3 and T4
    a_no_t3_t4: assert property (@(posedge clk) disable iff (!rst_n)
        !(settled_mask_reg[3] && settled_mask_reg[2]))
        else $error("settled mask holds both T3 and T4");

    // an idle sample clears the result at once
    a_idle_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_idle |=> (out_mask_reg == '0) && (settled_mask_reg == '0))
        else $error("idle sample did not clear the mask");

    // a slew hold never changes the settled mask
    a_slew_holds: assert property (@(posedge clk) disable iff (!rst_n)
        fire && slew_hold |=> $stable(settled_mask_reg) && (candidate_count_reg == '0))
        else $error("slew hold changed the settled mask");

    // input backpressure only when both registers are full and the output stalls
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> in_valid_reg && out_valid_reg && !chord_mask_ready)
        else $error("sample_ready low without a full, stalled pipeline");

    // the result register always shows the settled mask it was loaded from
    a_result_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (out_mask_reg == settled_mask_reg) && out_valid_reg)
        else $error("result differs from the settled mask");

endmodule
